>>> src/idr_pkg.sv
package idr_pkg;

	localparam int DIV_NUM_W = 73;
	localparam int DIV_DEN_W = 33;
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 33;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int SQRT_W = 52;
	localparam int ROOT_W = SQRT_W / 2 + 1;
	localparam int ACC_W = 76;
	localparam int RES_W = 54;
	localparam int W_W = 32;

	localparam logic [32:0] MICRO = 33'd1000000;
	localparam logic [24:0] GM_MAX = 25'h1000000;

	localparam logic [1:0] CFG_CALIB_TIME = 2'd0;
	localparam logic [1:0] CFG_CALIB_MIN = 2'd1;

	localparam logic [1:0] PH_FIRST = 2'd0;
	localparam logic [1:0] PH_CALIB = 2'd1;
	localparam logic [1:0] PH_RUN = 2'd2;

	typedef enum logic [1:0] {
		CTX_POS = 2'd0,
		CTX_ROT = 2'd1,
		CTX_VEL = 2'd2,
		CTX_GRAV = 2'd3
	} ctx_t;

	// Operand pairs of the ten quaternion products: xx yy zz ss xy xz yz sx sy sz.
	function automatic logic [1:0] quat_sel_a(input logic [3:0] j);
		logic [1:0] r;
		unique case (j)
			4'd0, 4'd4, 4'd5: r = 2'd0;
			4'd1, 4'd6: r = 2'd1;
			4'd2: r = 2'd2;
			default: r = 2'd3;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] quat_sel_b(input logic [3:0] j);
		logic [1:0] r;
		unique case (j)
			4'd0, 4'd7: r = 2'd0;
			4'd1, 4'd4, 4'd8: r = 2'd1;
			4'd2, 4'd5, 4'd6, 4'd9: r = 2'd2;
			default: r = 2'd3;
		endcase
		return r;
	endfunction

	function automatic logic signed [47:0] sat_s(input logic signed [55:0] v,
			input int unsigned w);
		logic signed [55:0] hi;
		logic signed [55:0] lo;
		logic signed [55:0] r;
		hi = (56'sd1 <<< (w - 1)) - 56'sd1;
		lo = -hi - 56'sd1;
		if (v > hi) begin
			r = hi;
		end else if (v < lo) begin
			r = lo;
		end else begin
			r = v;
		end
		return r[47:0];
	endfunction

endpackage

>>> src/idr_mul.sv
module idr_mul import idr_pkg::*; (
	input logic clk,
	input logic signed [MUL_A_W-1:0] a,
	input logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0] p
);

	logic signed [MUL_P_W-1:0] p_s1;

	always_ff @(posedge clk) begin
		p_s1 <= MUL_P_W'(a) * MUL_P_W'(b);
	end

	assign p = p_s1;

endmodule

>>> src/idr_div.sv
module idr_div import idr_pkg::*; #(
	parameter int NUM_W = DIV_NUM_W,
	parameter int DEN_W = DIV_DEN_W
) (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic [NUM_W-1:0] num,
	input logic [DEN_W-1:0] den,
	output logic done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DEN_W:0] trial;
	logic fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			quo_q <= '0;
			den_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (go) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
			cnt_q <= CNT_W'(NUM_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

>>> src/idr_sqrt.sv
module idr_sqrt import idr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic [SQRT_W-1:0] val,
	output logic done,
	output logic [ROOT_W-1:0] root
);

	logic [SQRT_W-1:0] v_q;
	logic [SQRT_W-1:0] r_q;
	logic [SQRT_W-1:0] bit_q;
	logic busy_q;
	logic fin_q;
	logic done_q;
	logic [ROOT_W-1:0] root_q;
	logic [SQRT_W-1:0] t;

	assign t = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			r_q <= '0;
			bit_q <= '0;
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			root_q <= '0;
		end else if (go) begin
			v_q <= val;
			r_q <= '0;
			bit_q <= SQRT_W'(1) << (SQRT_W - 2);
			busy_q <= 1'b1;
			fin_q <= 1'b0;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (v_q >= t) begin
				v_q <= v_q - t;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
			if (bit_q[0]) begin
				busy_q <= 1'b0;
				fin_q <= 1'b1;
			end
		end else if (fin_q) begin
			fin_q <= 1'b0;
			done_q <= 1'b1;
			root_q <= ROOT_W'(r_q) + ((v_q > r_q) ? ROOT_W'(1) : ROOT_W'(0));
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> src/imu_dead_reckoning_top.sv
// Strapdown dead reckoning, one IMU sample per item. The first item opens a gravity
// calibration; items are averaged until more than calib_time_us has passed since
// the first one and calib_min_samples have been summed, and produce no result.
// After that every item yields one result with position and velocity. While an
// item is worked on in_stall is high. A calibrating item holds in_stall for one
// cycle. The item that closes calibration makes three passes through the shared
// 73-step divider and runs the square root; a running item makes up to nine
// divider passes plus short multiply sequences, and in_stall stays high while its
// result waits on out_stall.
module imu_dead_reckoning_top import idr_pkg::*; #(
	parameter int COUNT_WIDTH = 20,
	parameter int ACCEL_FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [31:0] time_us,
	input logic signed [23:0] accel_x,
	input logic signed [23:0] accel_y,
	input logic signed [23:0] accel_z,
	input logic signed [15:0] quat_x,
	input logic signed [15:0] quat_y,
	input logic signed [15:0] quat_z,
	input logic signed [15:0] quat_w,
	output logic out_valid,
	input logic out_stall,
	output logic signed [47:0] pos_x,
	output logic signed [47:0] pos_y,
	output logic signed [47:0] pos_z,
	output logic signed [39:0] vel_x,
	output logic signed [39:0] vel_y,
	output logic signed [39:0] vel_z,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);

	localparam logic [31:0] GRAV_RESET =
		32'(((64'd981 << ACCEL_FRAC_BITS) + 64'd50) / 64'd100);

	typedef enum logic [15:0] {
		ST_IDLE = 16'h0001,
		ST_START = 16'h0002,
		ST_GSET = 16'h0004,
		ST_SC0 = 16'h0008,
		ST_SC1 = 16'h0010,
		ST_SC2 = 16'h0020,
		ST_DGO = 16'h0040,
		ST_DIVW = 16'h0080,
		ST_DONE = 16'h0100,
		ST_QM = 16'h0200,
		ST_QB = 16'h0400,
		ST_RM = 16'h0800,
		ST_RACC = 16'h1000,
		ST_GACC = 16'h2000,
		ST_SQW = 16'h4000,
		ST_OUT = 16'h8000
	} st_t;

	st_t state_q;
	ctx_t ctx_q;
	logic [1:0] phase_q;
	logic [31:0] calib_time_q;
	logic [19:0] calib_min_q;
	logic [31:0] t_q;
	logic signed [23:0] ax_q [3];
	logic signed [15:0] qt_q [4];
	logic [31:0] prev_q;
	logic [31:0] dt_q;
	logic signed [47:0] gsum_q [3];
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [31:0] grav_q;
	logic signed [47:0] pos_q [3];
	logic signed [39:0] vel_q [3];
	logic signed [W_W-1:0] w_q [3];
	logic signed [ACC_W-1:0] acc_q;
	logic neg_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic signed [RES_W-1:0] res_q;
	logic signed [MUL_A_W-1:0] m_q [9];
	logic signed [31:0] qp_q [10];
	logic [DIV_DEN_W-1:0] d_q;
	logic [SQRT_W-1:0] sq_q;
	logic [1:0] k_q;
	logic [3:0] j_q;
	logic [3:0] jd_q;
	logic pv_q;
	logic out_valid_q;
	logic signed [47:0] outp_q [3];
	logic signed [39:0] outv_q [3];

	logic in_acc;
	logic [31:0] dt;
	logic [COUNT_WIDTH-1:0] cnt_next;
	logic signed [47:0] gsum_next [3];
	logic signed [39:0] sc_val;
	logic [39:0] sc_mag;
	logic [ACC_W-1:0] acc_mag;
	logic [RES_W-1:0] res_mag;
	logic [24:0] gm;
	logic [3:0] mi;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	logic div_go;
	logic [DIV_NUM_W-1:0] div_num;
	logic div_done;
	logic [DIV_NUM_W-1:0] div_quo;
	logic [RES_W-1:0] quo_s;
	logic sqrt_go;
	logic sqrt_done;
	logic [ROOT_W-1:0] sqrt_root;
	logic [SQRT_W-1:0] sq_next;
	logic signed [35:0] pr [10];
	logic signed [35:0] dd;
	logic signed [35:0] mm [9];

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	assign dt = t_q - prev_q;
	assign cnt_next = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
	assign sc_val = (ctx_q == CTX_POS) ? vel_q[k_q] : 40'(w_q[k_q]);
	assign sc_mag = sc_val[39] ? 40'(-sc_val) : 40'(sc_val);
	assign acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign res_mag = res_q[RES_W-1] ? RES_W'(-res_q) : RES_W'(res_q);
	assign gm = (res_mag > RES_W'(GM_MAX)) ? GM_MAX : res_mag[24:0];
	assign mi = 4'({2'b00, k_q} * 4'd3 + j_q);
	assign quo_s = RES_W'(div_quo);
	assign div_go = (state_q == ST_DGO);
	assign div_num = DIV_NUM_W'(acc_mag) + DIV_NUM_W'(den_q >> 1);
	assign sq_next = sq_q + SQRT_W'(mul_p);
	assign sqrt_go = (state_q == ST_GACC) && (k_q == 2'd2);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			gsum_next[i] = sat_s(56'(gsum_q[i]) + 56'(ax_q[i]), 48);
		end
		for (int i = 0; i < 10; i++) begin
			pr[i] = 36'(qp_q[i]);
		end
		dd = pr[0] + pr[1] + pr[2] + pr[3];
		mm[0] = dd - ((pr[1] + pr[2]) <<< 1);
		mm[1] = (pr[4] - pr[9]) <<< 1;
		mm[2] = (pr[5] + pr[8]) <<< 1;
		mm[3] = (pr[4] + pr[9]) <<< 1;
		mm[4] = dd - ((pr[0] + pr[2]) <<< 1);
		mm[5] = (pr[6] - pr[7]) <<< 1;
		mm[6] = (pr[5] - pr[8]) <<< 1;
		mm[7] = (pr[6] + pr[7]) <<< 1;
		mm[8] = dd - ((pr[0] + pr[1]) <<< 1);
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SC0: begin
				mul_a = MUL_A_W'({1'b0, sc_mag[19:0]});
				mul_b = MUL_B_W'({1'b0, dt_q});
			end
			ST_SC1: begin
				mul_a = MUL_A_W'({1'b0, sc_mag[39:20]});
				mul_b = MUL_B_W'({1'b0, dt_q});
			end
			ST_QM: begin
				mul_a = MUL_A_W'(qt_q[quat_sel_a(j_q)]);
				mul_b = MUL_B_W'(qt_q[quat_sel_b(j_q)]);
			end
			ST_RM: begin
				mul_a = m_q[mi];
				mul_b = MUL_B_W'(ax_q[j_q[1:0]]);
			end
			ST_DONE: begin
				mul_a = MUL_A_W'({1'b0, gm});
				mul_b = MUL_B_W'({1'b0, gm});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	idr_mul u_mul (
		.clk(clk),
		.a(mul_a),
		.b(mul_b),
		.p(mul_p)
	);

	idr_div #(
		.NUM_W(DIV_NUM_W),
		.DEN_W(DIV_DEN_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.go(div_go),
		.num(div_num),
		.den(den_q),
		.done(div_done),
		.quo(div_quo)
	);

	idr_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.go(sqrt_go),
		.val(sq_next),
		.done(sqrt_done),
		.root(sqrt_root)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			t_q <= time_us;
			ax_q[0] <= accel_x;
			ax_q[1] <= accel_y;
			ax_q[2] <= accel_z;
			qt_q[0] <= quat_x;
			qt_q[1] <= quat_y;
			qt_q[2] <= quat_z;
			qt_q[3] <= quat_w;
		end
		if (state_q == ST_QM && pv_q) begin
			qp_q[jd_q] <= 32'(mul_p);
		end
		if (state_q == ST_QB) begin
			for (int i = 0; i < 9; i++) begin
				m_q[i] <= MUL_A_W'(mm[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ctx_q <= CTX_POS;
			phase_q <= PH_FIRST;
			calib_time_q <= 32'd3000000;
			calib_min_q <= 20'd100;
			prev_q <= '0;
			dt_q <= '0;
			cnt_q <= '0;
			grav_q <= GRAV_RESET;
			acc_q <= '0;
			neg_q <= 1'b0;
			den_q <= '0;
			res_q <= '0;
			d_q <= '0;
			sq_q <= '0;
			k_q <= '0;
			j_q <= '0;
			jd_q <= '0;
			pv_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				gsum_q[i] <= '0;
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				w_q[i] <= '0;
				outp_q[i] <= '0;
				outv_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_CALIB_TIME: calib_time_q <= cfg_data;
					CFG_CALIB_MIN: calib_min_q <= cfg_data[19:0];
					default: ;
				endcase
			end
			if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			pv_q <= (state_q == ST_QM) || (state_q == ST_RM);
			jd_q <= j_q;

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					if (phase_q == PH_FIRST) begin
						for (int i = 0; i < 3; i++) begin
							gsum_q[i] <= 48'(ax_q[i]);
						end
						cnt_q <= COUNT_WIDTH'(1);
						prev_q <= t_q;
						phase_q <= PH_CALIB;
						state_q <= ST_IDLE;
					end else if (phase_q == PH_CALIB) begin
						for (int i = 0; i < 3; i++) begin
							gsum_q[i] <= gsum_next[i];
						end
						cnt_q <= cnt_next;
						if (dt > calib_time_q && 32'(cnt_next) >= 32'(calib_min_q)) begin
							prev_q <= t_q;
							phase_q <= PH_RUN;
							k_q <= '0;
							sq_q <= '0;
							state_q <= ST_GSET;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						prev_q <= t_q;
						dt_q <= dt;
						k_q <= '0;
						ctx_q <= CTX_POS;
						state_q <= ST_SC0;
					end
				end
				ST_GSET: begin
					acc_q <= ACC_W'(gsum_q[k_q]);
					neg_q <= 1'b0;
					den_q <= DIV_DEN_W'(cnt_q);
					ctx_q <= CTX_GRAV;
					state_q <= ST_DGO;
				end
				ST_SC0: begin
					acc_q <= '0;
					neg_q <= sc_val[39];
					den_q <= MICRO;
					state_q <= ST_SC1;
				end
				ST_SC1: begin
					acc_q <= acc_q + ACC_W'(mul_p);
					state_q <= ST_SC2;
				end
				ST_SC2: begin
					acc_q <= acc_q + (ACC_W'(mul_p) <<< 20);
					state_q <= ST_DGO;
				end
				ST_DGO: begin
					neg_q <= neg_q ^ acc_q[ACC_W-1];
					state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (div_done) begin
						res_q <= neg_q ? RES_W'(-quo_s) : RES_W'(quo_s);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					unique case (ctx_q)
						CTX_POS: begin
							pos_q[k_q] <= sat_s(56'(pos_q[k_q]) + 56'(res_q), 48);
							if (k_q == 2'd2) begin
								j_q <= '0;
								state_q <= ST_QM;
							end else begin
								k_q <= k_q + 1'b1;
								state_q <= ST_SC0;
							end
						end
						CTX_ROT: begin
							w_q[k_q] <= W_W'(36'(res_q) -
								((k_q == 2'd2) ? 36'(grav_q) : 36'd0));
							acc_q <= '0;
							j_q <= '0;
							if (k_q == 2'd2) begin
								k_q <= '0;
								ctx_q <= CTX_VEL;
								state_q <= ST_SC0;
							end else begin
								k_q <= k_q + 1'b1;
								state_q <= ST_RM;
							end
						end
						CTX_VEL: begin
							vel_q[k_q] <= 40'(sat_s(56'(vel_q[k_q]) + 56'(res_q), 40));
							if (k_q == 2'd2) begin
								state_q <= ST_OUT;
							end else begin
								k_q <= k_q + 1'b1;
								state_q <= ST_SC0;
							end
						end
						default: begin
							state_q <= ST_GACC;
						end
					endcase
				end
				ST_GACC: begin
					sq_q <= sq_next;
					if (k_q == 2'd2) begin
						state_q <= ST_SQW;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= ST_GSET;
					end
				end
				ST_SQW: begin
					if (sqrt_done) begin
						grav_q <= 32'(sqrt_root);
						state_q <= ST_IDLE;
					end
				end
				ST_QM: begin
					if (j_q == 4'd10) begin
						state_q <= ST_QB;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_QB: begin
					d_q <= DIV_DEN_W'(dd);
					k_q <= '0;
					j_q <= '0;
					acc_q <= '0;
					ctx_q <= CTX_ROT;
					state_q <= ST_RM;
				end
				ST_RM: begin
					if (pv_q) begin
						acc_q <= acc_q + ACC_W'(mul_p);
					end
					if (j_q == 4'd2) begin
						state_q <= ST_RACC;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_RACC: begin
					if (d_q == '0) begin
						res_q <= RES_W'(ax_q[k_q]);
						state_q <= ST_DONE;
					end else begin
						acc_q <= acc_q + ACC_W'(mul_p);
						neg_q <= 1'b0;
						den_q <= d_q;
						state_q <= ST_DGO;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						for (int i = 0; i < 3; i++) begin
							outp_q[i] <= pos_q[i];
							outv_q[i] <= vel_q[i];
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign pos_x = outp_q[0];
	assign pos_y = outp_q[1];
	assign pos_z = outp_q[2];
	assign vel_x = outv_q[0];
	assign vel_y = outv_q[1];
	assign vel_z = outv_q[2];

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_START)
		else $error("accepted item did not start processing");

	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIVW)
		else $error("divider finished while no quotient was awaited");

	a_sqrt_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> state_q == ST_SQW)
		else $error("root finished while no root was awaited");

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FIRST || phase_q == PH_CALIB || phase_q == PH_RUN)
		else $error("calibration phase register corrupted");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import idr_pkg::*;

	typedef struct {
		logic [31:0] t;
		logic signed [23:0] a [3];
		logic signed [15:0] q [4];
	} sample_t;

	typedef struct {
		logic signed [47:0] pos [3];
		logic signed [39:0] vel [3];
	} pose_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] time_us = '0;
	logic signed [23:0] accel_x = '0, accel_y = '0, accel_z = '0;
	logic signed [15:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [47:0] pos_x, pos_y, pos_z;
	logic signed [39:0] vel_x, vel_y, vel_z;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	imu_dead_reckoning_top uut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	sample_t pending_samples [$];
	pose_t pose_expected [$];
	int mismatches = 0;
	int in_gap = 0;
	int out_wait = 0;
	bit no_idle = 1'b0;

	// Predictor state.
	logic [31:0] calib_time_p = 32'd3000000;
	logic [19:0] calib_min_p = 20'd100;
	logic [1:0] nav_phase = PH_FIRST;
	logic [31:0] prev_stamp = '0;
	longint grav_sum [3] = '{0, 0, 0};
	longint unsigned sum_count = 0;
	longint unsigned grav_mag = ((64'd981 << 16) + 64'd50) / 64'd100;
	longint nav_pos [3] = '{0, 0, 0};
	longint nav_vel [3] = '{0, 0, 0};

	function automatic longint clamp_bits(longint v, int w);
		longint hi;
		hi = (longint'(1) <<< (w - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	function automatic longint unsigned mag_of(longint v);
		return v < 0 ? longint'(0) - v : v;
	endfunction

	function automatic longint round_div(longint num, longint unsigned den);
		longint unsigned quo;
		quo = (mag_of(num) + den / 2) / den;
		return num < 0 ? -longint'(quo) : longint'(quo);
	endfunction

	function automatic longint times_dt(longint v, logic [31:0] dt);
		longint unsigned a, hi, lo, q1, r1, quo;
		a = mag_of(v);
		hi = a * dt[31:16];
		lo = a * dt[15:0];
		q1 = hi / 64'd1000000;
		r1 = hi % 64'd1000000;
		quo = (q1 << 16) + ((r1 << 16) + lo + 64'd500000) / 64'd1000000;
		return v < 0 ? -longint'(quo) : longint'(quo);
	endfunction

	function automatic longint unsigned root_round(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (v > r) r++;
		return r;
	endfunction

	task automatic integrate_sample(input sample_t s);
		longint a [3], w [3], m [3][3];
		longint x, y, z, sc, d, sq;
		longint unsigned acc, mm;
		logic [31:0] dt;
		pose_t res;
		for (int k = 0; k < 3; k++) a[k] = s.a[k];
		if (nav_phase == PH_FIRST) begin
			for (int k = 0; k < 3; k++) grav_sum[k] = a[k];
			sum_count = 1;
			prev_stamp = s.t;
			nav_phase = PH_CALIB;
			return;
		end
		dt = s.t - prev_stamp;
		if (nav_phase == PH_CALIB) begin
			for (int k = 0; k < 3; k++) grav_sum[k] = clamp_bits(grav_sum[k] + a[k], 48);
			if (sum_count < 64'hFFFFF) sum_count++;
			if (dt > calib_time_p && sum_count >= calib_min_p) begin
				acc = 0;
				for (int k = 0; k < 3; k++) begin
					mm = mag_of(round_div(grav_sum[k], sum_count));
					if (mm > (64'd1 << 24)) mm = 64'd1 << 24;
					acc += mm * mm;
				end
				grav_mag = root_round(acc);
				prev_stamp = s.t;
				nav_phase = PH_RUN;
			end
			return;
		end
		prev_stamp = s.t;
		for (int k = 0; k < 3; k++)
			nav_pos[k] = clamp_bits(nav_pos[k] + times_dt(nav_vel[k], dt), 48);
		x = s.q[0];
		y = s.q[1];
		z = s.q[2];
		sc = s.q[3];
		d = x * x + y * y + z * z + sc * sc;
		if (d == 0) begin
			for (int k = 0; k < 3; k++) w[k] = a[k];
		end else begin
			m[0][0] = d - 2 * (y * y + z * z);
			m[0][1] = 2 * (x * y - sc * z);
			m[0][2] = 2 * (x * z + sc * y);
			m[1][0] = 2 * (x * y + sc * z);
			m[1][1] = d - 2 * (x * x + z * z);
			m[1][2] = 2 * (y * z - sc * x);
			m[2][0] = 2 * (x * z - sc * y);
			m[2][1] = 2 * (y * z + sc * x);
			m[2][2] = d - 2 * (x * x + y * y);
			for (int k = 0; k < 3; k++) begin
				sq = m[k][0] * a[0] + m[k][1] * a[1] + m[k][2] * a[2];
				w[k] = round_div(sq, d);
			end
		end
		w[2] = w[2] - longint'(grav_mag);
		for (int k = 0; k < 3; k++) begin
			nav_vel[k] = clamp_bits(nav_vel[k] + times_dt(w[k], dt), 40);
			res.pos[k] = nav_pos[k][47:0];
			res.vel[k] = nav_vel[k][39:0];
		end
		pose_expected.push_back(res);
	endtask

	task automatic present(input sample_t s);
		time_us <= s.t;
		accel_x <= s.a[0];
		accel_y <= s.a[1];
		accel_z <= s.a[2];
		quat_x <= s.q[0];
		quat_y <= s.q[1];
		quat_z <= s.q[2];
		quat_w <= s.q[3];
		in_valid <= 1'b1;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				integrate_sample('{time_us, '{accel_x, accel_y, accel_z},
					'{quat_x, quat_y, quat_z, quat_w}});
				if ($urandom_range(0, 63) == 0) no_idle = !no_idle;
				in_gap = no_idle ? 0 : $urandom_range(0, 3);
				if (in_gap == 0 && pending_samples.size() > 0) begin
					present(pending_samples.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end else if (!in_valid) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (pending_samples.size() > 0) begin
					present(pending_samples.pop_front());
				end
			end
		end
	end

	always @(posedge clk) begin
		pose_t got, want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.pos = '{pos_x, pos_y, pos_z};
				got.vel = '{vel_x, vel_y, vel_z};
				if (pose_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result pos %0d %0d %0d",
						pos_x, pos_y, pos_z);
				end else begin
					want = pose_expected.pop_front();
					for (int k = 0; k < 3; k++) begin
						if (got.pos[k] !== want.pos[k] || got.vel[k] !== want.vel[k]) begin
							mismatches++;
							if (mismatches <= 10)
								$display("axis %0d: pos exp %0d got %0d, vel exp %0d got %0d",
									k, want.pos[k], got.pos[k], want.vel[k], got.vel[k]);
						end
					end
				end
				out_wait = no_idle ? 0 : $urandom_range(0, 3);
			end else if (out_wait > 0) begin
				out_wait--;
			end
			out_stall <= (out_wait > 0);
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_CALIB_TIME) calib_time_p = data;
		else if (idx == CFG_CALIB_MIN) calib_min_p = data[19:0];
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_samples.size() > 0 || in_valid || in_stall || pose_expected.size() > 0)
			@(posedge clk);
		repeat (1000) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_quat();
		return 16'($signed(17'($urandom_range(0, 32768))) - 17'sd16384);
	endfunction

	function automatic sample_t make_sample(logic [31:0] t, int unsigned kind);
		sample_t s;
		s.t = t;
		for (int k = 0; k < 3; k++)
			s.a[k] = (kind == 0) ? 24'($urandom()) :
				$signed(24'($urandom_range(0, 2097151))) - 24'sd1048576;
		for (int k = 0; k < 4; k++) s.q[k] = rand_quat();
		return s;
	endfunction

	initial begin
		logic [31:0] t;
		sample_t s;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		write_reg(CFG_CALIB_TIME, 32'd2000);
		write_reg(CFG_CALIB_MIN, 32'd5);
		write_reg(2'd3, 32'hFFFFFFFF);
		t = 32'hFFFFF800;
		// Calibration wraps the timestamp past zero.
		for (int i = 0; i < 8; i++) begin
			s = '{t, '{24'sd1000, -24'sd2000, 24'sd642908}, '{16'sd0, 16'sd0, 16'sd0, 16'sd16384}};
			pending_samples.push_back(s);
			t += 500;
		end
		s = '{t, '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF}, '{16'sd0, 16'sd0, 16'sd0, 16'sd0}};
		pending_samples.push_back(s);
		t += 1000;
		s = '{t, '{24'sh800000, 24'sh800000, 24'sh800000}, '{16'sd0, 16'sd0, 16'sd0, 16'sd0}};
		pending_samples.push_back(s);
		for (int j = 0; j < 8; j++) begin
			t += 700;
			s = '{t, '{24'sh7FFFFF, 24'sh800000, 24'sd12345}, '{16'sd0, 16'sd0, 16'sd0, 16'sd0}};
			s.q[j % 4] = (j < 4) ? 16'sd16384 : -16'sd16384;
			pending_samples.push_back(s);
		end
		t += 900;
		s = '{t, '{24'sd5, -24'sd7, 24'sd9}, '{-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384}};
		pending_samples.push_back(s);
		t += 32'hF0000000;
		s = '{t, '{24'sd0, 24'sd0, 24'sd0}, '{16'sd3, -16'sd5, 16'sd7, 16'sd11}};
		pending_samples.push_back(s);
		wait_idle();
		write_reg(CFG_CALIB_TIME, 32'd0);
		write_reg(CFG_CALIB_MIN, 32'd0);
		write_reg(CFG_CALIB_TIME, 32'hFFFFFFFF);
		write_reg(CFG_CALIB_MIN, 32'hFFFFF);
		for (int p = 0; p < 4; p++) begin
			for (int i = 0; i < 450; i++) begin
				if ($urandom_range(0, 19) == 0) t = $urandom();
				else t += $urandom_range(1, 5000);
				pending_samples.push_back(make_sample(t, $urandom_range(0, 7)));
			end
			wait_idle();
			write_reg(2'($urandom_range(0, 1)), $urandom());
		end
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#60000000;
		$display("tb: failure");
		$finish;
	end

endmodule
